// ----- sv/co2afp_pkg.sv -----
// Package for the CO2 ASCII frame parser: byte codes, frame sizes and the
// digit-value helper. No dependencies; imported by the core, the checker and the testbench.
package co2afp_pkg;

  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam int STORE_DEPTH = 9;
  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] STORE_LIMIT = CNT_W'(STORE_DEPTH);
  localparam logic [CNT_W-1:0] FRAME_LEN = CNT_W'(10);

  localparam int NUM_DIGITS = 5;
  localparam int PPM_W = 16;
  localparam int SUM_W = 17;

  typedef logic [7:0] byte_t;
  typedef logic [SUM_W-1:0] sum_t;

  // Decimal value of one ASCII digit; any other byte counts as zero.
  function automatic logic [3:0] digit_value(input byte_t c);
    logic [7:0] d;
    begin
      d = c - CHAR_ZERO;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        digit_value = d[3:0];
      end else begin
        digit_value = 4'd0;
      end
    end
  endfunction

endpackage

// ----- sv/co2_ascii_frame_parser_core.sv -----
// Top level of the CO2 ASCII frame parser: input register, frame state,
// digit store and result register. Depends on co2afp_pkg.
//
// Usage:
//   Input channel (in_*): one request per byte received from the sensor's
//   serial line, in in_tdata. Result channel (out_*): one request per
//   complete frame (nine data bytes, CR, LF) carrying the decoded ppm value.
//   The value is the first five stored bytes read as decimal digits,
//   ten-thousands down to units, non-digits adding nothing, modulo 65536.
//   Order: a byte is held in the input register, then its frame update
//   happens; for an LF that closes a valid frame the result is then
//   registered and appears on out_tvalid from the result register.
//   Throughput: one byte per cycle unless an emitting byte waits on a full
//   result register, set by the combinational update of the frame state and
//   the constant-weight digit sum ahead of the result register.
//   Stall: while a result waits on out_tready, bytes that produce no result
//   still advance; only a byte that would emit a second result waits in the
//   input register, and in_tready drops behind it.
//   Reset (rst_n low, synchronous): frame state cleared (no CR seen, count
//   zero), both pipeline registers emptied. The digit store is not cleared;
//   a frame only reads entries written since its last restart.
module co2_ascii_frame_parser_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  co2afp_pkg::byte_t         in_tdata,   // [7:0] rx_byte
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [co2afp_pkg::PPM_W-1:0] out_tdata  // [15:0] ppm_value
);
  import co2afp_pkg::*;

  // Input register
  logic  in_vld_r, in_vld_nxt;
  byte_t in_byte_r;

  // Frame state
  logic             cr_seen_r, cr_seen_nxt;
  logic [CNT_W-1:0] char_count_r, char_count_nxt;
  byte_t            digit_store_r [STORE_DEPTH];

  // Result register
  logic             out_vld_r, out_vld_nxt;
  logic [PPM_W-1:0] out_data_r;

  logic is_lf, is_cr, emit, out_free, s1_go, store_we;
  sum_t ppm_sum;

  assign is_lf    = (in_byte_r == BYTE_LF);
  assign is_cr    = (in_byte_r == BYTE_CR);
  assign emit     = is_lf && cr_seen_r && (char_count_r == FRAME_LEN);
  assign out_free = !out_vld_r || out_tready;
  // Advance the held byte unless it emits while the result slot is full.
  assign s1_go    = in_vld_r && (!emit || out_free);
  assign in_tready = !in_vld_r || s1_go;

  // Weighted digit sum over the first five stored bytes.
  always_comb begin
    ppm_sum = SUM_W'(digit_value(digit_store_r[0])) * SUM_W'(10000)
            + SUM_W'(digit_value(digit_store_r[1])) * SUM_W'(1000)
            + SUM_W'(digit_value(digit_store_r[2])) * SUM_W'(100)
            + SUM_W'(digit_value(digit_store_r[3])) * SUM_W'(10)
            + SUM_W'(digit_value(digit_store_r[4]));
  end

  // Frame state update for the byte in the input register.
  always_comb begin
    cr_seen_nxt    = cr_seen_r;
    char_count_nxt = char_count_r;
    store_we       = 1'b0;
    if (s1_go) begin
      if (is_lf) begin
        cr_seen_nxt    = 1'b0;
        char_count_nxt = '0;
      end else if (is_cr) begin
        if (!cr_seen_r) begin
          cr_seen_nxt    = 1'b1;
          char_count_nxt = char_count_r + CNT_W'(1);
        end else begin
          cr_seen_nxt    = 1'b0;
          char_count_nxt = '0;
        end
      end else if (char_count_r < STORE_LIMIT) begin
        store_we       = 1'b1;
        char_count_nxt = char_count_r + CNT_W'(1);
      end else begin
        // Data byte with the count at the store limit or past it: drop it and restart the frame.
        cr_seen_nxt    = 1'b0;
        char_count_nxt = '0;
      end
    end
  end

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_tready) begin
      in_vld_nxt = in_tvalid;
    end
    out_vld_nxt = out_vld_r;
    if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
    if (s1_go && emit) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      cr_seen_r    <= 1'b0;
      char_count_r <= '0;
      out_vld_r    <= 1'b0;
    end else begin
      in_vld_r     <= in_vld_nxt;
      cr_seen_r    <= cr_seen_nxt;
      char_count_r <= char_count_nxt;
      out_vld_r    <= out_vld_nxt;
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
    if (store_we) begin
      digit_store_r[char_count_r] <= in_byte_r;
    end
    if (s1_go && emit) begin
      out_data_r <= ppm_sum[PPM_W-1:0];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // The count never runs past a full frame.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    char_count_r <= FRAME_LEN)
    else $error("frame count beyond frame length");

  // A full count is only reached through the CR.
  a_full_needs_cr: assert property (@(posedge clk) disable iff (!rst_n)
    (char_count_r == FRAME_LEN) |-> cr_seen_r)
    else $error("full frame count without CR");

  // An emitted frame lands in the result register.
  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && emit) |=> out_vld_r)
    else $error("emitted value lost");

  // A held byte keeps its value until it advances.
  a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !s1_go) |=> (in_vld_r && $stable(in_byte_r)))
    else $error("held byte changed");

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |-> !(s1_go && emit))
    else $error("result overwritten while stalled");

endmodule

// ----- tb/co2afp_ppm_checker.sv -----
// Result checker for the CO2 ASCII frame parser: watches both stream channels,
// predicts each ppm value from the accepted bytes and compares in order.
// Depends on co2afp_pkg.
module co2afp_ppm_checker (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  input  logic                    in_tready,
  input  co2afp_pkg::byte_t       in_tdata,
  input  logic                    out_tvalid,
  input  logic                    out_tready,
  input  logic [co2afp_pkg::PPM_W-1:0] out_tdata,
  output int                      mismatch_count,
  output int                      ppm_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import co2afp_pkg::*;

  // Own copy of the frame state.
  bit                   frame_armed;
  logic [CNT_W-1:0]     frame_chars;
  byte_t                frame_bytes [STORE_DEPTH];

  logic [PPM_W-1:0]     ppm_expected_q [$];

  initial begin
    mismatch_count = 0;
    ppm_pending    = 0;
    foreach (frame_bytes[i]) frame_bytes[i] = '0;
  end

  task automatic report_mismatch(input string what, input logic [PPM_W-1:0] got,
                                 input logic [PPM_W-1:0] want);
    $display("%0t ns: ppm check: %s (got %0d, expected %0d)", $time, what, got, want);
    mismatch_count++;
  endtask

  // Read the first five stored bytes as decimal digits, most significant first.
  function automatic logic [PPM_W-1:0] frame_ppm();
    int acc;
    acc = 0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      acc = acc * 10;
      if (frame_bytes[i] >= CHAR_ZERO && frame_bytes[i] <= CHAR_NINE)
        acc = acc + int'(frame_bytes[i] - CHAR_ZERO);
    end
    return PPM_W'(acc);
  endfunction

  task automatic restart_frame();
    frame_armed = 1'b0;
    frame_chars = '0;
  endtask

  task automatic advance_frame(input byte_t rx);
    if (rx == BYTE_LF) begin
      if (frame_armed && frame_chars == FRAME_LEN)
        ppm_expected_q.push_back(frame_ppm());
      restart_frame();
    end else if (rx == BYTE_CR) begin
      if (!frame_armed) begin
        frame_armed = 1'b1;
        frame_chars = frame_chars + 1'b1;
      end else begin
        restart_frame();
      end
    end else if (frame_chars < STORE_LIMIT) begin
      frame_bytes[frame_chars] = rx;
      frame_chars = frame_chars + 1'b1;
    end else begin
      restart_frame();
    end
  endtask

  always @(posedge clk) begin
    logic [PPM_W-1:0] want;
    if (!rst_n) begin
      restart_frame();
      ppm_expected_q.delete();
    end else begin
      // Retire the result first: it is always older than a byte taken this edge.
      if (out_tvalid && out_tready) begin
        if (ppm_expected_q.size() == 0) begin
          report_mismatch("result with no frame pending", out_tdata, '0);
        end else begin
          want = ppm_expected_q.pop_front();
          if (out_tdata !== want)
            report_mismatch("wrong ppm_value", out_tdata, want);
        end
      end
      if (in_tvalid && in_tready)
        advance_frame(in_tdata);
    end
    ppm_pending <= ppm_expected_q.size();
  end

endmodule

// ----- tb/co2_ascii_frame_parser_core_test.sv -----
// Top-level testbench of co2_ascii_frame_parser_core: clock, reset, byte
// stimulus, receiver stalls, watchdog and verdict. Depends on co2afp_pkg,
// the core and co2afp_ppm_checker.
module co2_ascii_frame_parser_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import co2afp_pkg::*;

  localparam int RANDOM_BYTES  = 1850;
  localparam int IDLE_LIMIT    = 2000;  // cycles with no request moving
  localparam int DRAIN_CYCLES  = 8;     // margin to catch a stray result

  // Receiver behavior, switched at random intervals.
  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_PATTERN,
    READY_RARE
  } ready_mode_e;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  byte_t            in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [PPM_W-1:0] out_tdata;

  int               mismatch_count;
  int               ppm_pending;

  int               burst_left;
  int               random_sent;
  int               idle_cycles;
  ready_mode_e      ready_mode;
  int               ready_mode_left;
  logic [2:0]       ready_phase;

  co2_ascii_frame_parser_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  co2afp_ppm_checker i_ppm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .ppm_pending    (ppm_pending)
  );

  // 10 ns clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: hold out_tready on a mode that changes at random intervals,
  // from never stalling to stalling almost all the time.
  always @(negedge clk) begin
    if (ready_mode_left == 0) begin
      ready_mode      <= ready_mode_e'($urandom_range(0, 3));
      ready_mode_left <= $urandom_range(16, 96);
    end else begin
      ready_mode_left <= ready_mode_left - 1;
    end
    ready_phase <= ready_phase + 1'b1;
    case (ready_mode)
      READY_ALWAYS:  out_tready <= 1'b1;
      READY_MOSTLY:  out_tready <= ($urandom_range(0, 9) < 7);
      READY_PATTERN: out_tready <= (ready_phase < 3'd3);
      default:       out_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // Watchdog: end the run when no request moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Offer one byte and hold it until the core takes it. The sender runs in
  // bursts; between bursts drop in_tvalid for a random gap with noise on the data.
  // Call at a falling edge; returns at a falling edge.
  task automatic send_rx_byte(input byte_t rx);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 24);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        in_tdata  <= byte_t'($urandom);
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= rx;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Payload byte for a frame: mostly ASCII digits, otherwise any byte that is
  // neither CR nor LF.
  function automatic byte_t payload_byte();
    byte_t b;
    if ($urandom_range(0, 9) < 7)
      return CHAR_ZERO + byte_t'($urandom_range(0, 9));
    do b = byte_t'($urandom); while (b == BYTE_CR || b == BYTE_LF);
    return b;
  endfunction

  task automatic send_random(input byte_t rx);
    send_rx_byte(rx);
    random_sent++;
  endtask

  task automatic send_payload(input int count);
    repeat (count) send_random(payload_byte());
  endtask

  initial begin
    byte_t edge_bytes [9];
    int    cr_slot;

    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    out_tready      = 1'b0;
    burst_left      = 0;
    random_sent     = 0;
    idle_cycles     = 0;
    ready_mode      = READY_ALWAYS;
    ready_mode_left = 0;
    ready_phase     = '0;
    edge_bytes      = '{8'h00, 8'hFF, 8'h2F, 8'h3A, CHAR_ZERO, 8'h80, 8'h7F, CHAR_NINE, 8'h41};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: a full frame of nines, whose value wraps past 16 bits.
    repeat (9) send_rx_byte(CHAR_NINE);
    send_rx_byte(BYTE_CR);
    send_rx_byte(BYTE_LF);

    // Directed: byte extremes and digit-boundary neighbors as data, then a
    // tenth data byte that restarts the frame.
    foreach (edge_bytes[i]) send_rx_byte(edge_bytes[i]);
    send_rx_byte(8'h42);

    // Directed: LF on an idle frame, then a CR followed by a second CR.
    send_rx_byte(BYTE_LF);
    send_rx_byte(BYTE_CR);
    send_rx_byte(BYTE_CR);

    // Random: mostly well-formed frames with random payload, the rest broken
    // frames and raw noise.
    while (random_sent < RANDOM_BYTES) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          send_payload(9);
          send_random(BYTE_CR);
          send_random(BYTE_LF);
        end
        6: begin
          // CR too early: the frame can no longer reach its full length.
          cr_slot = $urandom_range(0, 8);
          for (int i = 0; i < 10; i++) begin
            if (i == cr_slot) send_random(BYTE_CR);
            else              send_random(payload_byte());
          end
          send_random(BYTE_LF);
        end
        7: begin
          // Short or overlong payload before CR LF.
          send_payload(($urandom_range(0, 1) == 0) ? $urandom_range(0, 8)
                                                   : $urandom_range(10, 12));
          send_random(BYTE_CR);
          send_random(BYTE_LF);
        end
        8: begin
          // Full payload with a doubled CR.
          send_payload(9);
          send_random(BYTE_CR);
          send_random(BYTE_CR);
          send_random(BYTE_LF);
        end
        default: begin
          // Raw noise over the whole byte range.
          repeat ($urandom_range(1, 8)) send_random(byte_t'($urandom));
        end
      endcase
    end
    in_tvalid <= 1'b0;

    // Drain: wait for every predicted ppm value, then wait out the drain margin to
    // catch any stray result. The watchdog bounds this wait.
    while (ppm_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
